/* rtl/core/msc_pkg.sv */
// shared types, constants and crc function for the mode s crc and address check
`timescale 1ns / 1ps

package msc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 14;
  localparam int MIN_FRAME_BYTES     = 5;
  localparam int PARITY_BYTES        = 3;

  localparam logic [23:0] CRC_POLY = 24'hFFF409;

  // downlink formats
  localparam logic [4:0] DF_SHORT_ACAS = 5'd0;
  localparam logic [4:0] DF_SURV_ALT   = 5'd4;
  localparam logic [4:0] DF_SURV_ID    = 5'd5;
  localparam logic [4:0] DF_ALL_CALL   = 5'd11;
  localparam logic [4:0] DF_LONG_ACAS  = 5'd16;
  localparam logic [4:0] DF_EXT_SQ     = 5'd17;
  localparam logic [4:0] DF_EXT_SQ_NT  = 5'd18;
  localparam logic [4:0] DF_COMM_B_ALT = 5'd20;
  localparam logic [4:0] DF_COMM_B_ID  = 5'd21;

  typedef enum logic [1:0] {
    INTEG_GOOD        = 2'd0,
    INTEG_BAD         = 2'd1,
    INTEG_NOT_CHECKED = 2'd2
  } integrity_t;

  typedef struct packed {
    logic [4:0]  format_bits;
    logic [4:0]  type_bits;
    logic [23:0] address_bytes;
    logic [23:0] syndrome;
    logic [3:0]  length;
    logic        length_error;
  } frame_summary_t;

  // byte-parallel crc-24 update, msb first
  function automatic logic [23:0] crc_feed_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] r;
    logic        top;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      top = r[23] ^ b[i];
      r   = {r[22:0], 1'b0};
      if (top) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/msc_input_reg.sv */
// input register for incoming frame bytes
`timescale 1ns / 1ps

module msc_input_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  input  logic       out_free,
  output logic       advance,
  output logic       fire,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic held_valid;

  assign advance    = held_valid && (!held_last || out_free);
  assign fire       = advance && held_last;
  assign byte_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      held_byte <= frame_byte;
      held_last <= last_byte;
    end
  end

endmodule

/* rtl/core/msc_frame_state.sv */
// per-frame crc, parity delay line and header capture
`timescale 1ns / 1ps

module msc_frame_state #(
  parameter int MAX_FRAME_BYTES = msc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [7:0]              held_byte,
  input  logic                    held_last,
  output msc_pkg::frame_summary_t summary
);

  localparam logic [3:0] MaxBytes = 4'(MAX_FRAME_BYTES);
  localparam logic [3:0] MinBytes = 4'(msc_pkg::MIN_FRAME_BYTES);
  localparam logic [3:0] ParBytes = 4'(msc_pkg::PARITY_BYTES);

  logic [23:0] crc_register;
  logic [7:0]  parity_delay [3];
  logic [3:0]  byte_count;
  logic [4:0]  format_bits;
  logic [23:0] address_bytes;
  logic [4:0]  type_bits;
  logic        overflow;

  logic [23:0] crc_register_next;
  logic [7:0]  parity_delay_next [3];
  logic [3:0]  byte_count_next;
  logic [4:0]  format_bits_next;
  logic [23:0] address_bytes_next;
  logic [4:0]  type_bits_next;
  logic        overflow_next;
  logic        full;

  always_comb begin
    full = byte_count >= MaxBytes;
    crc_register_next  = crc_register;
    parity_delay_next  = parity_delay;
    byte_count_next    = byte_count;
    format_bits_next   = format_bits;
    address_bytes_next = address_bytes;
    type_bits_next     = type_bits;
    overflow_next      = overflow || full;
    if (!full) begin
      if (byte_count >= ParBytes) begin
        crc_register_next = msc_pkg::crc_feed_byte(crc_register, parity_delay[2]);
      end
      parity_delay_next[2] = parity_delay[1];
      parity_delay_next[1] = parity_delay[0];
      parity_delay_next[0] = held_byte;
      if (byte_count == 4'd0) begin
        format_bits_next = held_byte[7:3];
      end else if (byte_count <= ParBytes) begin
        address_bytes_next = {address_bytes[15:0], held_byte};
      end else if (byte_count == ParBytes + 4'd1) begin
        type_bits_next = held_byte[7:3];
      end
      byte_count_next = byte_count + 4'd1;
    end
  end

  always_comb begin
    summary.format_bits   = format_bits_next;
    summary.type_bits     = type_bits_next;
    summary.address_bytes = address_bytes_next;
    summary.syndrome      = crc_register_next ^
                            {parity_delay_next[2], parity_delay_next[1], parity_delay_next[0]};
    summary.length        = byte_count_next;
    summary.length_error  = overflow_next || (byte_count_next < MinBytes);
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && held_last)) begin
      crc_register    <= '0;
      parity_delay[0] <= '0;
      parity_delay[1] <= '0;
      parity_delay[2] <= '0;
      byte_count      <= '0;
      format_bits     <= '0;
      address_bytes   <= '0;
      type_bits       <= '0;
      overflow        <= 1'b0;
    end else if (advance) begin
      crc_register  <= crc_register_next;
      parity_delay  <= parity_delay_next;
      byte_count    <= byte_count_next;
      format_bits   <= format_bits_next;
      address_bytes <= address_bytes_next;
      type_bits     <= type_bits_next;
      overflow      <= overflow_next;
    end
  end

  // a frame end always leaves the accumulator empty
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && held_last |=> byte_count == 4'd0 && !overflow && crc_register == '0)
    else $error("frame state not cleared after last byte");

  // the count never passes the frame limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MaxBytes)
    else $error("byte count beyond frame limit");

endmodule

/* rtl/core/msc_result_reg.sv */
// verdict logic and output register for frame results
`timescale 1ns / 1ps

module msc_result_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  msc_pkg::frame_summary_t summary,
  output logic                    out_free,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [4:0]              downlink_format,
  output logic [4:0]              type_code,
  output logic                    type_code_valid,
  output logic [1:0]              integrity,
  output logic [23:0]             syndrome,
  output logic [23:0]             aircraft_address,
  output logic                    address_valid,
  output logic [3:0]              frame_length,
  output logic                    length_error
);

  logic [4:0]          tc;
  logic                tc_ok;
  msc_pkg::integrity_t integ;
  logic [23:0]         addr;
  logic                addr_ok;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    tc      = '0;
    tc_ok   = 1'b0;
    integ   = msc_pkg::INTEG_NOT_CHECKED;
    addr    = '0;
    addr_ok = 1'b0;
    if (!summary.length_error) begin
      case (summary.format_bits) inside
        msc_pkg::DF_EXT_SQ, msc_pkg::DF_EXT_SQ_NT: begin
          tc      = summary.type_bits;
          tc_ok   = 1'b1;
          integ   = (summary.syndrome == '0) ? msc_pkg::INTEG_GOOD : msc_pkg::INTEG_BAD;
          addr    = summary.address_bytes;
          addr_ok = 1'b1;
        end
        msc_pkg::DF_ALL_CALL: begin
          integ   = (summary.syndrome == '0) ? msc_pkg::INTEG_GOOD : msc_pkg::INTEG_BAD;
          addr    = summary.address_bytes;
          addr_ok = 1'b1;
        end
        msc_pkg::DF_SHORT_ACAS, msc_pkg::DF_SURV_ALT, msc_pkg::DF_SURV_ID,
        msc_pkg::DF_LONG_ACAS, msc_pkg::DF_COMM_B_ALT, msc_pkg::DF_COMM_B_ID: begin
          addr    = summary.syndrome;
          addr_ok = 1'b1;
        end
        default: begin
          addr_ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      downlink_format  <= summary.format_bits;
      type_code        <= tc;
      type_code_valid  <= tc_ok;
      integrity        <= integ;
      syndrome         <= summary.syndrome;
      aircraft_address <= addr;
      address_valid    <= addr_ok;
      frame_length     <= summary.length;
      length_error     <= summary.length_error;
    end
  end

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    fire |-> out_free)
    else $error("result register overwritten while stalled");

  // a checked crc implies a reported address
  a_checked_has_addr: assert property (@(posedge clk) disable iff (rst)
    result_valid && integrity != msc_pkg::INTEG_NOT_CHECKED |-> address_valid && !length_error)
    else $error("crc verdict without address");

  // short frames always flag a length error
  a_short_flagged: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_length < 4'(msc_pkg::MIN_FRAME_BYTES) |-> length_error)
    else $error("short frame not flagged");

endmodule

/* rtl/core/mode_s_crc_address_check.sv */
// top level of the mode s crc-24 parity and address check
`timescale 1ns / 1ps

// Takes a Mode S frame one byte per transfer, msb first, with last_byte on the
// final byte, and gives one result per frame. A byte is taken every cycle while
// byte_stall is low; the crc-24 update of a whole byte, the verdict and the address
// selection are combinational between the input register and the result register,
// which loads a result as its last byte leaves the input register. byte_stall
// rises only when a last byte is waiting and the previous result is still stalled.
// The final three bytes of a frame are its parity field; bytes beyond
// MAX_FRAME_BYTES are dropped and flagged as a length error.
module mode_s_crc_address_check #(
  parameter int MAX_FRAME_BYTES = msc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [4:0]  downlink_format,
  output logic [4:0]  type_code,
  output logic        type_code_valid,
  output logic [1:0]  integrity,
  output logic [23:0] syndrome,
  output logic [23:0] aircraft_address,
  output logic        address_valid,
  output logic [3:0]  frame_length,
  output logic        length_error
);

  logic                    out_free;
  logic                    advance;
  logic                    fire;
  logic [7:0]              held_byte;
  logic                    held_last;
  msc_pkg::frame_summary_t summary;

  msc_input_reg u_input (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .out_free   (out_free),
    .advance    (advance),
    .fire       (fire),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  msc_frame_state #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .held_byte (held_byte),
    .held_last (held_last),
    .summary   (summary)
  );

  msc_result_reg u_result (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .summary          (summary),
    .out_free         (out_free),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .downlink_format  (downlink_format),
    .type_code        (type_code),
    .type_code_valid  (type_code_valid),
    .integrity        (integrity),
    .syndrome         (syndrome),
    .aircraft_address (aircraft_address),
    .address_valid    (address_valid),
    .frame_length     (frame_length),
    .length_error     (length_error)
  );

endmodule

/* sim/tb_mode_s_crc_address_check.sv */
// testbench for mode_s_crc_address_check: directed table plus random frames
`timescale 1ns / 1ps

module tb_mode_s_crc_address_check;

  localparam int MAX_BYTES   = msc_pkg::MAX_FRAME_BYTES_DEF;
  localparam int ITEM_TARGET = 800;
  localparam int LONG_HOLD   = 160;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    logic [4:0]          df;
    logic [4:0]          tc;
    logic                tc_ok;
    msc_pkg::integrity_t integ;
    logic [23:0]         syn;
    logic [23:0]         icao;
    logic                icao_ok;
    logic [3:0]          len;
    logic                len_err;
  } frame_report_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          last;
    logic          typed;
    frame_report_t want;
  } stim_row_t;

  localparam frame_report_t NO_REPORT =
    '{5'd0, 5'd0, 1'b0, msc_pkg::INTEG_GOOD, 24'd0, 24'd0, 1'b0, 4'd0, 1'b0};

  localparam logic [4:0] KNOWN_DF [0:8] = '{msc_pkg::DF_SHORT_ACAS, msc_pkg::DF_SURV_ALT,
    msc_pkg::DF_SURV_ID, msc_pkg::DF_ALL_CALL, msc_pkg::DF_LONG_ACAS, msc_pkg::DF_EXT_SQ,
    msc_pkg::DF_EXT_SQ_NT, msc_pkg::DF_COMM_B_ALT, msc_pkg::DF_COMM_B_ID};

  // one-byte frame, all-zero minimum frame, overlong all-ones frame, short all-call frame
  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    '{8'hFF, 1'b1, 1'b1,
      '{5'd31, 5'd0, 1'b0, msc_pkg::INTEG_NOT_CHECKED, 24'h0000FF, 24'd0, 1'b0, 4'd1, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, 1'b0, NO_REPORT},
    '{8'h00, 1'b1, 1'b1,
      '{5'd0, 5'd0, 1'b0, msc_pkg::INTEG_NOT_CHECKED, 24'd0, 24'd0, 1'b1, 4'd5, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, 1'b0, NO_REPORT},
    '{8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{8'h58, 1'b0, 1'b0, NO_REPORT},
    '{8'hAA, 1'b0, 1'b0, NO_REPORT},
    '{8'h55, 1'b0, 1'b0, NO_REPORT},
    '{8'h0F, 1'b1, 1'b0, NO_REPORT}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        result_valid;
  logic        result_stall;
  logic [4:0]  downlink_format;
  logic [4:0]  type_code;
  logic        type_code_valid;
  logic [1:0]  integrity;
  logic [23:0] syndrome;
  logic [23:0] aircraft_address;
  logic        address_valid;
  logic [3:0]  frame_length;
  logic        length_error;

  // predictor state
  logic [23:0] crc_acc;
  logic [7:0]  parity_line [0:2];
  logic [3:0]  bytes_taken;
  logic [4:0]  df_hold;
  logic [23:0] icao_hold;
  logic [4:0]  tc_hold;
  logic        overrun;

  frame_report_t pending_reports [$];
  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  idle_cycles  = 0;
  bit  tx_gaps      = 1'b1;
  bit  rx_gaps      = 1'b1;
  bit  hold_request = 1'b0;

  mode_s_crc_address_check dut (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .downlink_format  (downlink_format),
    .type_code        (type_code),
    .type_code_valid  (type_code_valid),
    .integrity        (integrity),
    .syndrome         (syndrome),
    .aircraft_address (aircraft_address),
    .address_valid    (address_valid),
    .frame_length     (frame_length),
    .length_error     (length_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [23:0] crc24_byte(input logic [23:0] acc, input logic [7:0] b);
    logic [23:0] r;
    r = acc ^ {b, 16'd0};
    repeat (8) r = r[23] ? ({r[22:0], 1'b0} ^ msc_pkg::CRC_POLY) : {r[22:0], 1'b0};
    return r;
  endfunction

  function automatic void clear_frame_state();
    crc_acc        = '0;
    parity_line[0] = '0;
    parity_line[1] = '0;
    parity_line[2] = '0;
    bytes_taken    = '0;
    df_hold        = '0;
    icao_hold      = '0;
    tc_hold        = '0;
    overrun        = 1'b0;
  endfunction

  // advances the predictor by one byte; returns 1 with the frame report on a last byte
  function automatic bit absorb_byte(input logic [7:0] b, input logic l,
                                     output frame_report_t rep);
    rep = NO_REPORT;
    if (bytes_taken >= MAX_BYTES) begin
      overrun = 1'b1;
    end else begin
      if (bytes_taken >= msc_pkg::PARITY_BYTES) crc_acc = crc24_byte(crc_acc, parity_line[2]);
      parity_line[2] = parity_line[1];
      parity_line[1] = parity_line[0];
      parity_line[0] = b;
      if (bytes_taken == 0) df_hold = b[7:3];
      else if (bytes_taken <= 3) icao_hold = {icao_hold[15:0], b};
      else if (bytes_taken == 4) tc_hold = b[7:3];
      bytes_taken++;
    end
    if (!l) return 1'b0;
    rep.df      = df_hold;
    rep.syn     = crc_acc ^ {parity_line[2], parity_line[1], parity_line[0]};
    rep.len     = bytes_taken;
    rep.len_err = overrun || (bytes_taken < msc_pkg::MIN_FRAME_BYTES);
    rep.integ   = msc_pkg::INTEG_NOT_CHECKED;
    if (!rep.len_err) begin
      case (df_hold) inside
        msc_pkg::DF_ALL_CALL, msc_pkg::DF_EXT_SQ, msc_pkg::DF_EXT_SQ_NT: begin
          rep.integ   = (rep.syn == 24'd0) ? msc_pkg::INTEG_GOOD : msc_pkg::INTEG_BAD;
          rep.icao    = icao_hold;
          rep.icao_ok = 1'b1;
          if (df_hold != msc_pkg::DF_ALL_CALL) begin
            rep.tc    = tc_hold;
            rep.tc_ok = 1'b1;
          end
        end
        msc_pkg::DF_SHORT_ACAS, msc_pkg::DF_SURV_ALT, msc_pkg::DF_SURV_ID,
        msc_pkg::DF_LONG_ACAS, msc_pkg::DF_COMM_B_ALT, msc_pkg::DF_COMM_B_ID: begin
          rep.icao    = rep.syn;
          rep.icao_ok = 1'b1;
        end
        default: ;
      endcase
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // offers one byte and returns at the edge where the transfer happens
  task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                           input frame_report_t want);
    int gap;
    frame_report_t rep;
    gap = tx_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    frame_byte <= b;
    last_byte  <= l;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    if (absorb_byte(b, l, rep)) begin
      pending_reports.insert(pending_reports.size(), typed ? want : rep);
    end
  endtask

  task automatic send_random_frame();
    logic [7:0]  fr [0:17];
    logic [23:0] acc;
    logic [23:0] mask;
    logic [4:0]  df;
    int          n;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) n = 7;
    else if (pick < 8) n = 14;
    else if (pick == 8) n = $urandom_range(5, MAX_BYTES);
    else n = $urandom_range(1, MAX_BYTES + 4);
    for (int i = 0; i < 18; i++) fr[i] = 8'($urandom);
    pick = $urandom_range(0, 11);
    df = (pick < 9) ? KNOWN_DF[pick] : 5'($urandom);
    fr[0] = {df, fr[0][2:0]};
    // mostly well-formed parity: clean for checked formats, address overlay for the rest
    if (n >= msc_pkg::MIN_FRAME_BYTES && n <= MAX_BYTES && $urandom_range(0, 3) != 0) begin
      acc = '0;
      for (int i = 0; i < n - msc_pkg::PARITY_BYTES; i++) acc = crc24_byte(acc, fr[i]);
      if (df == msc_pkg::DF_ALL_CALL || df == msc_pkg::DF_EXT_SQ || df == msc_pkg::DF_EXT_SQ_NT)
        mask = '0;
      else mask = 24'($urandom);
      if ($urandom_range(0, 7) == 0) mask ^= 24'd1 << $urandom_range(0, 23);
      {fr[n - 3], fr[n - 2], fr[n - 1]} = acc ^ mask;
    end
    for (int i = 0; i < n; i++) push_byte(fr[i], i == n - 1, 1'b0, NO_REPORT);
  endtask

  // result side
  initial begin
    int hold;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (hold_request) begin
          hold         = LONG_HOLD;
          hold_request = 1'b0;
        end else begin
          hold = rx_gaps ? $urandom_range(0, 17) : 0;
        end
        if (hold > 0) begin
          result_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          result_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    frame_report_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected result: expected none actual df %0h syndrome %0h",
                 $time, downlink_format, syndrome);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("downlink_format", 24'(want.df), 24'(downlink_format));
        check_field("type_code", 24'(want.tc), 24'(type_code));
        check_field("type_code_valid", 24'(want.tc_ok), 24'(type_code_valid));
        check_field("integrity", 24'(want.integ), 24'(integrity));
        check_field("syndrome", want.syn, syndrome);
        check_field("aircraft_address", want.icao, aircraft_address);
        check_field("address_valid", 24'(want.icao_ok), 24'(address_valid));
        check_field("frame_length", 24'(want.len), 24'(frame_length));
        check_field("length_error", 24'(want.len_err), 24'(length_error));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("mode_s_crc_address_check verification failed");
        $finish;
      end
    end
  end

  initial begin
    int frame_no;
    rst        = 1'b1;
    byte_valid = 1'b0;
    frame_byte = '0;
    last_byte  = 1'b0;
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 25; i++) begin
      push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
    end

    frame_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      // frames 8..12 run back to back into a long result hold-off
      if (frame_no >= 8 && frame_no < 13) tx_gaps = 1'b0;
      else tx_gaps = $urandom_range(0, 2) != 0;
      rx_gaps = $urandom_range(0, 2) != 0;
      if (frame_no == 8) hold_request = 1'b1;
      if (frame_no == 13 || frame_no == 40) begin
        byte_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
      end
      send_random_frame();
      frame_no++;
    end

    byte_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("mode_s_crc_address_check verification clean");
    end else begin
      $display("mode_s_crc_address_check verification failed");
    end
    $finish;
  end

endmodule
